// File: rtl/itp_pkg.sv
package itp_pkg;

	// Most results one item can cause; the stack never holds more entries.
	localparam int MAX_RESULTS = 16;

	localparam int CODE_W = 3;
	localparam int RANK_W = 3;

	// Operator codes held on the stack
	localparam logic [CODE_W-1:0] CODE_LPAR  = 3'd0;
	localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd1;
	localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
	localparam logic [CODE_W-1:0] CODE_MUL   = 3'd3;
	localparam logic [CODE_W-1:0] CODE_DIV   = 3'd4;
	localparam logic [CODE_W-1:0] CODE_POW   = 3'd5;

	// Characters
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// One result word headed for the output register
	typedef struct packed {
		logic       vld;
		logic [7:0] chr;
		logic       has;
		logic       last;
		logic       ovf;
	} res_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic pend_vld;
		logic ovf;
	} stat_t;

	function automatic logic is_letter(input logic [7:0] s);
		return s inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
	endfunction

	function automatic logic is_oper(input logic [7:0] s);
		return s inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW};
	endfunction

	function automatic logic [CODE_W-1:0] oper_code(input logic [7:0] s);
		logic [CODE_W-1:0] c;
		case (s)
			CH_PLUS:  c = CODE_PLUS;
			CH_MINUS: c = CODE_MINUS;
			CH_MUL:   c = CODE_MUL;
			CH_DIV:   c = CODE_DIV;
			CH_POW:   c = CODE_POW;
			default:  c = CODE_LPAR;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] code_char(input logic [CODE_W-1:0] c);
		logic [7:0] ch;
		case (c)
			CODE_LPAR:  ch = CH_LPAR;
			CODE_PLUS:  ch = CH_PLUS;
			CODE_MINUS: ch = CH_MINUS;
			CODE_MUL:   ch = CH_MUL;
			CODE_DIV:   ch = CH_DIV;
			CODE_POW:   ch = CH_POW;
			default:    ch = CH_NONE;
		endcase
		return ch;
	endfunction

	function automatic logic [RANK_W-1:0] code_rank(input logic [CODE_W-1:0] c);
		logic [RANK_W-1:0] r;
		case (c)
			CODE_PLUS, CODE_MINUS: r = 3'd2;
			CODE_MUL, CODE_DIV:    r = 3'd4;
			CODE_POW:              r = 3'd5;
			default:               r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/itp_in_if.sv
interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_of_expr;

	modport source (output valid, output symbol, output end_of_expr, input ready);
	modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

// File: rtl/itp_out_if.sv
interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       run_last;
	logic       overflow;

	modport source (output valid, output out_char, output has_char, output run_last,
		output overflow, input ready);
	modport sink (input valid, input out_char, input has_char, input run_last,
		input overflow, output ready);
endinterface

// File: rtl/itp_ram.sv
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read data holds until the next read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/itp_seq.sv
module itp_seq #(
	parameter int CAP    = 16,
	parameter int CNT_W  = 5,
	parameter int ADDR_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                symbol,
	input  logic                      end_of_expr,
	input  logic                      out_free,
	output itp_pkg::res_t             res,
	output itp_pkg::stat_t            stat,
	output logic                      ram_we,
	output logic [ADDR_W-1:0]         ram_waddr,
	output logic [itp_pkg::CODE_W-1:0] ram_wdata,
	output logic                      ram_re,
	output logic [ADDR_W-1:0]         ram_raddr,
	input  logic [itp_pkg::CODE_W-1:0] ram_rdata
);

	import itp_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	localparam logic [1:0] M_FLUSH = 2'd0;
	localparam logic [1:0] M_OP    = 2'd1;
	localparam logic [1:0] M_CLOSE = 2'd2;

	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	logic [1:0]        state_q, state_d;
	logic [1:0]        mode_q, mode_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              ovf_q, ovf_d;
	logic [CODE_W-1:0] opc_q, opc_d;
	logic              pend_vld_q, pend_vld_d;
	logic [7:0]        pend_chr_q, pend_chr_d;

	logic [CNT_W-1:0]  cnt_m1, cnt_m2;
	logic              pop_emit;

	assign cnt_m1 = cnt_q - CNT_ONE;
	assign cnt_m2 = cnt_q - CNT_TWO;

	// Does the entry just read leave the stack as an output character?
	always_comb begin
		case (mode_q)
			M_FLUSH: pop_emit = 1'b1;
			M_OP:    pop_emit = (code_rank(ram_rdata) >= code_rank(opc_q));
			M_CLOSE: pop_emit = (ram_rdata != CODE_LPAR);
			default: pop_emit = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		cnt_d      = cnt_q;
		ovf_d      = ovf_q;
		opc_d      = opc_q;
		pend_vld_d = pend_vld_q;
		pend_chr_d = pend_chr_q;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[ADDR_W-1:0];
		ram_wdata  = opc_q;
		ram_re     = 1'b0;
		ram_raddr  = cnt_m1[ADDR_W-1:0];
		res        = '0;
		in_ready   = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					if (end_of_expr) begin
						if (cnt_q == '0) begin
							res.vld  = 1'b1;
							res.last = 1'b1;
							res.ovf  = ovf_q;
						end else begin
							ram_re  = 1'b1;
							mode_d  = M_FLUSH;
							state_d = S_POP;
						end
					end else if (is_letter(symbol)) begin
						res.vld  = 1'b1;
						res.chr  = symbol;
						res.has  = 1'b1;
						res.last = 1'b1;
						res.ovf  = ovf_q;
					end else if (is_oper(symbol)) begin
						opc_d = oper_code(symbol);
						if (cnt_q == '0) begin
							ram_we    = 1'b1;
							ram_wdata = oper_code(symbol);
							cnt_d     = cnt_q + CNT_ONE;
						end else begin
							ram_re  = 1'b1;
							mode_d  = M_OP;
							state_d = S_POP;
						end
					end else if (symbol == CH_LPAR) begin
						if (cnt_q == CNT_CAP) begin
							ovf_d = 1'b1;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = CODE_LPAR;
							cnt_d     = cnt_q + CNT_ONE;
						end
					end else if (symbol == CH_RPAR && cnt_q != '0) begin
						ram_re  = 1'b1;
						mode_d  = M_CLOSE;
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				if (pop_emit) begin
					// the held character is not last: another one follows
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							res.vld = 1'b1;
							res.chr = pend_chr_q;
							res.has = 1'b1;
							res.ovf = ovf_q;
						end
						pend_vld_d = 1'b1;
						pend_chr_d = code_char(ram_rdata);
						cnt_d      = cnt_m1;
						if (cnt_m1 != '0) begin
							ram_re    = 1'b1;
							ram_raddr = cnt_m2[ADDR_W-1:0];
						end else begin
							state_d = S_FIN;
						end
					end
				end else begin
					// drop the matching open parenthesis
					if (mode_q == M_CLOSE)
						cnt_d = cnt_m1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!pend_vld_q || out_free) begin
					if (pend_vld_q) begin
						res.vld  = 1'b1;
						res.chr  = pend_chr_q;
						res.has  = 1'b1;
						res.last = 1'b1;
						res.ovf  = ovf_q;
					end
					pend_vld_d = 1'b0;
					if (mode_q == M_OP) begin
						if (cnt_q == CNT_CAP) begin
							ovf_d = 1'b1;
						end else begin
							ram_we = 1'b1;
							cnt_d  = cnt_q + CNT_ONE;
						end
					end
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_FLUSH;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			cnt_q      <= cnt_d;
			ovf_q      <= ovf_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		opc_q      <= opc_d;
		pend_chr_q <= pend_chr_d;
	end

	assign stat.pend_vld = pend_vld_q;
	assign stat.ovf      = ovf_q;

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Infix to postfix converter (shunting yard, all operators left associative).
//
// in_ch  : one infix character per word (symbol), or an end word (end_of_expr = 1)
//          that flushes the operator stack.
// out_ch : postfix characters. run_last marks the last word caused by one input
//          word; has_char = 0 marks the single word sent for a flush of an empty
//          stack. overflow is the sticky flag of a push dropped on a full stack.
//
// Sequence: a letter or an end word on an empty stack is taken and its word shows
// on out_ch the next cycle. An item that pops stack entries is taken and starts the
// stack read, then pops one entry per step (one RAM read per cycle while out_ch does
// not stall), then finishes (and pushes an operator). If it stops at an entry it keeps
// (a lower operator or the matching '('), one more step goes to that entry. No new
// item is taken until the sequencer is back in idle. Each popped character is held
// until the next entry is examined, so that run_last is known when it leaves.
//
// Reset clears the stack pointer, the overflow flag and the output valid bit;
// the stack RAM and the output payload are not cleared. If out_ch stalls, the converter holds in
// place and in_ch is not ready until the output register can take a new word.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	itp_in_if.sink  in_ch,
	itp_out_if.source out_ch
);

	import itp_pkg::*;

	// Capacity is clamped so that no word causes more than MAX_RESULTS results
	localparam int CAP    = (STACK_DEPTH > MAX_RESULTS) ? MAX_RESULTS : STACK_DEPTH;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int ADDR_W = $clog2(CAP);

	res_t  res;
	stat_t stat;
	logic  out_free;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CODE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CODE_W-1:0] ram_rdata;

	// Output register
	logic       out_vld_q;
	logic [7:0] out_chr_q;
	logic       out_has_q;
	logic       out_last_q;
	logic       out_ovf_q;

	// A new word may be loaded when the register is empty or drains this cycle
	assign out_free = !out_vld_q || out_ch.ready;

	// Operator stack storage
	itp_ram #(
		.WIDTH (CODE_W),
		.DEPTH (CAP)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Stack pointer and pop/push sequencer
	itp_seq #(
		.CAP    (CAP),
		.CNT_W  (CNT_W),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.symbol      (in_ch.symbol),
		.end_of_expr (in_ch.end_of_expr),
		.out_free    (out_free),
		.res         (res),
		.stat        (stat),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// Load a word from the sequencer, or drop the word the sink just took
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.vld) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (res.vld) begin
			out_chr_q  <= res.chr;
			out_has_q  <= res.has;
			out_last_q <= res.last;
			out_ovf_q  <= res.ovf;
		end
	end

	assign out_ch.valid    = out_vld_q;
	assign out_ch.out_char = out_chr_q;
	assign out_ch.has_char = out_has_q;
	assign out_ch.run_last = out_last_q;
	assign out_ch.overflow = out_ovf_q;

`ifndef ASSERT_OFF
	// No popped character may be left behind when a new word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !stat.pend_vld)
		else $error("held character left over when accepting a new word");

	// The stack RAM is never written and read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("stack RAM written and read in one cycle");

	// Overflow flag is sticky
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.ovf |=> stat.ovf)
		else $error("overflow flag cleared");

	// The empty flush marker is always last and carries no character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.has_char |-> out_ch.run_last && out_ch.out_char == CH_NONE)
		else $error("malformed empty flush marker");
`endif

endmodule
